### rtl/pst_pkg.sv
// Shared types and codes for the positional symbol table.
package pst_pkg;

  typedef struct packed {
    logic       opcode;
    logic [6:0] char_code;
    logic       is_last;
    logic [7:0] sym_type;
  } pst_in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] type_out;
  } pst_out_t;

  typedef struct packed {
    logic       valid;
    logic [6:0] hash;
    logic [7:0] sym_type;
  } pst_slot_t;

  localparam int SLOT_W = $bits(pst_slot_t);

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_DUPLICATE = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_FOUND     = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;
  localparam logic [2:0] ST_BAD_NAME  = 3'd5;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHAR,
    S_PROBE_RD,
    S_PROBE_CHK,
    S_RESP
  } pst_state_t;

endpackage

### rtl/positional_symbol_table_core.sv
// Top level of the positional symbol table: control sequencer and both memories.
//
// Names arrive one character per transfer. For each character the presence row for its position
// is read, then the bit is checked, or set and the row written back on an insert. On the last
// character an insert or lookup walks the slot list of its cell, one slot at a time (slot
// memory read, then check and possible write), up to SLOTS_PER_CELL slots, then hands the
// result to the output register; bad names and rejected lookups skip the walk. After reset
// the block clears all MAX_NAME_LEN*ALPHABET_SIZE*SLOTS_PER_CELL slot memory entries (24064
// by default), and the presence rows with them, before it takes its first character.
module positional_symbol_table_core
  import pst_pkg::*;
#(
  parameter int MAX_NAME_LEN   = 16,
  parameter int SLOTS_PER_CELL = 16,
  parameter int ALPHABET_SIZE  = 94,
  parameter int CHAR_BASE      = 33
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  pst_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output pst_out_t out_data
);

  localparam int SLOT_D = MAX_NAME_LEN * ALPHABET_SIZE * SLOTS_PER_CELL;
  localparam int SAW    = $clog2(SLOT_D);
  localparam int ROW_AW = (MAX_NAME_LEN > 1) ? $clog2(MAX_NAME_LEN) : 1;
  localparam int POS_W  = $clog2(MAX_NAME_LEN + 1);
  localparam int OFF_W  = (SLOTS_PER_CELL > 1) ? $clog2(SLOTS_PER_CELL) : 1;

  pst_state_t state_r, state_nxt;

  pst_in_t          item_r;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [6:0]       hash_r, hash_nxt;
  logic             rej_r, rej_nxt;
  logic             inv_r, inv_nxt;
  logic [SAW-1:0]   base_r, base_nxt;
  logic [6:0]       key_r, key_nxt;
  logic [OFF_W-1:0] off_r, off_nxt;
  logic [OFF_W-1:0] cnt_r, cnt_nxt;
  logic [SAW-1:0]   clr_r;
  logic [2:0]       res_st_r, res_st_nxt;
  logic [7:0]       res_ty_r, res_ty_nxt;
  logic             out_valid_r;
  pst_out_t         out_r;

  // presence memory signals
  logic                     pres_we, pres_re;
  logic [ROW_AW-1:0]        pres_waddr, pres_raddr;
  logic [ALPHABET_SIZE-1:0] pres_wdata, pres_q, pres_row_set;
  logic                     pres_bit;

  // slot memory signals
  logic           slot_we, slot_re;
  logic [SAW-1:0] slot_waddr, slot_raddr;
  pst_slot_t      slot_wdata, slot_q;
  logic [SLOT_W-1:0] slot_q_raw;

  logic           char_ok, char_use, last_done, clr_last, probe_end, skip_probe;
  logic [6:0]     idx;
  logic [14:0]    home_red;
  logic [SAW-1:0] probe_addr;

  assign slot_q = pst_slot_t'(slot_q_raw);

  pst_ram #(.W(ALPHABET_SIZE), .D(MAX_NAME_LEN), .AW(ROW_AW)) u_presence (
    .clk   (clk),
    .we    (pres_we),
    .waddr (pres_waddr),
    .wdata (pres_wdata),
    .re    (pres_re),
    .raddr (pres_raddr),
    .rdata (pres_q)
  );

  pst_ram #(.W(SLOT_W), .D(SLOT_D), .AW(SAW)) u_slots (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .re    (slot_re),
    .raddr (slot_raddr),
    .rdata (slot_q_raw)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign clr_last   = (clr_r == SAW'(SLOT_D - 1));
  assign probe_addr = base_r + SAW'(off_r);
  assign probe_end  = (cnt_r == OFF_W'(SLOTS_PER_CELL - 1));

  // character classification for the latched item
  assign idx     = item_r.char_code - 7'(CHAR_BASE);
  assign char_ok = (item_r.char_code >= 7'(CHAR_BASE))
                && ({1'b0, idx} < 8'(ALPHABET_SIZE))
                && (pos_r < POS_W'(MAX_NAME_LEN));
  assign char_use = !inv_r && char_ok;

  always_comb begin
    pres_bit = 1'b0;
    for (int j = 0; j < ALPHABET_SIZE; j++) begin
      pres_row_set[j] = pres_q[j] || (idx == 7'(j));
      if (idx == 7'(j)) pres_bit = pres_q[j];
    end
  end

  // home slot: hash modulo slot count by shifted compare and subtract
  always_comb begin
    home_red = 15'(key_nxt);
    for (int k = 6; k >= 0; k--) begin
      if (home_red >= (15'(SLOTS_PER_CELL) << k)) begin
        home_red = home_red - (15'(SLOTS_PER_CELL) << k);
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR:     if (clr_last) state_nxt = S_IDLE;
      S_IDLE:      if (in_valid) state_nxt = S_CHAR;
      S_CHAR: begin
        if (!item_r.is_last) state_nxt = S_IDLE;
        else if (skip_probe) state_nxt = S_RESP;
        else state_nxt = S_PROBE_RD;
      end
      S_PROBE_RD:  state_nxt = S_PROBE_CHK;
      S_PROBE_CHK: state_nxt = (last_done || probe_end) ? S_RESP : S_PROBE_RD;
      S_RESP:      if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    pos_nxt    = pos_r;
    hash_nxt   = hash_r;
    rej_nxt    = rej_r;
    inv_nxt    = inv_r;
    base_nxt   = base_r;
    key_nxt    = key_r;
    off_nxt    = off_r;
    cnt_nxt    = cnt_r;
    res_st_nxt = res_st_r;
    res_ty_nxt = res_ty_r;
    last_done  = 1'b0;
    skip_probe = 1'b0;
    pres_re    = 1'b0;
    pres_raddr = pos_r[ROW_AW-1:0];
    pres_we    = 1'b0;
    pres_waddr = pos_r[ROW_AW-1:0];
    pres_wdata = pres_row_set;
    slot_re    = 1'b0;
    slot_raddr = probe_addr;
    slot_we    = 1'b0;
    slot_waddr = probe_addr;
    slot_wdata = '{valid: 1'b1, hash: key_r, sym_type: item_r.sym_type};
    case (state_r)
      S_CLEAR: begin
        slot_we    = 1'b1;
        slot_waddr = clr_r;
        slot_wdata = '0;
        pres_we    = (clr_r < SAW'(MAX_NAME_LEN));
        pres_waddr = clr_r[ROW_AW-1:0];
        pres_wdata = '0;
      end
      S_IDLE: begin
        pres_re = in_valid;
      end
      S_CHAR: begin
        if (!inv_r && !char_ok) inv_nxt = 1'b1;
        if (char_use) begin
          hash_nxt = hash_r ^ item_r.char_code;
          if (item_r.opcode == OP_INSERT) pres_we = 1'b1;
          else if (!pres_bit) rej_nxt = 1'b1;
        end
        if (pos_r < POS_W'(MAX_NAME_LEN)) pos_nxt = pos_r + 1'b1;
        if (item_r.is_last) begin
          // bad names and rejected lookups answer without walking the slots
          skip_probe = inv_nxt || (item_r.opcode == OP_LOOKUP && rej_nxt);
          base_nxt = SAW'((SAW'(pos_r) * SAW'(ALPHABET_SIZE) + SAW'(idx))
                          * SAW'(SLOTS_PER_CELL));
          key_nxt    = hash_nxt;
          off_nxt    = OFF_W'(home_red);
          cnt_nxt    = '0;
          res_ty_nxt = '0;
          res_st_nxt = inv_nxt ? ST_BAD_NAME : ST_NOT_FOUND;
          pos_nxt    = '0;
          hash_nxt   = '0;
          rej_nxt    = 1'b0;
          inv_nxt    = 1'b0;
        end
      end
      S_PROBE_RD: begin
        slot_re = 1'b1;
      end
      S_PROBE_CHK: begin
        if (item_r.opcode == OP_INSERT) begin
          if (!slot_q.valid) begin
            slot_we    = 1'b1;
            res_st_nxt = ST_INSERTED;
            last_done  = 1'b1;
          end else if (slot_q.hash == key_r) begin
            res_st_nxt = ST_DUPLICATE;
            last_done  = 1'b1;
          end else if (probe_end) begin
            res_st_nxt = ST_FULL;
          end
        end else begin
          if (slot_q.valid && slot_q.hash == key_r) begin
            res_st_nxt = ST_FOUND;
            res_ty_nxt = slot_q.sym_type;
            last_done  = 1'b1;
          end else if (probe_end) begin
            res_st_nxt = ST_NOT_FOUND;
          end
        end
        cnt_nxt = cnt_r + 1'b1;
        off_nxt = (off_r == OFF_W'(SLOTS_PER_CELL - 1)) ? '0 : off_r + 1'b1;
      end
      S_RESP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      pos_r       <= '0;
      hash_r      <= '0;
      rej_r       <= 1'b0;
      inv_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_r <= clr_r + 1'b1;
      pos_r  <= pos_nxt;
      hash_r <= hash_nxt;
      rej_r  <= rej_nxt;
      inv_r  <= inv_nxt;
      if (state_r == S_RESP && (!out_valid_r || out_ready)) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) item_r <= in_data;
    base_r   <= base_nxt;
    key_r    <= key_nxt;
    off_r    <= off_nxt;
    cnt_r    <= cnt_nxt;
    res_st_r <= res_st_nxt;
    res_ty_r <= res_ty_nxt;
    if (state_r == S_RESP && (!out_valid_r || out_ready)) begin
      out_r <= '{status: res_st_r, type_out: res_ty_r};
    end
  end

  // a result carries a type only when it was found
  a_type_only_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.status != ST_FOUND |-> out_r.type_out == 8'd0)
    else $error("type_out nonzero on a result other than found");

  // a probe insert overwrites only an empty slot
  a_insert_empty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PROBE_CHK && slot_we |-> !slot_q.valid && item_r.opcode == OP_INSERT)
    else $error("insert wrote over an occupied slot");

  // a new result appears only after the response state
  a_result_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_RESP)
    else $error("result raised outside the response state");

  // a held result is not replaced while it waits
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(out_r))
    else $error("pending result changed before transfer");

endmodule

### rtl/pst_ram.sv
// Single-port-write, registered-read synchronous RAM.
module pst_ram #(
  parameter int W  = 16,
  parameter int D  = 16,
  parameter int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
